### hw/rtl/pipk_pkg.sv
// pipk_pkg: shared types, constants and helper functions of the paletted index word packer
// no dependencies; imported by every module of the block

package pipk_pkg;

   localparam int ARRAY_LENGTH = 4096;
   localparam int POS_W        = (ARRAY_LENGTH > 1) ? $clog2(ARRAY_LENGTH) : 1;
   localparam int WORD_W       = 32;
   localparam int INDEX_W      = 16;
   localparam int SLOT_W       = 5;
   localparam int BITS_W       = 5;
   localparam int SPAN_W       = SLOT_W + BITS_W;
   localparam int HDR_W        = 8;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

   // one packing step, handed from the front to the back
   typedef struct packed {
      logic [INDEX_W-1:0] value;      // already masked to bits per value
      logic [SLOT_W-1:0]  shift;      // bit offset inside the word
      logic               fits;       // offset is inside the word
      logic               first;      // first value of an array: header result
      logic               close;      // word is finished after this value
      logic               last;       // last value of the array
      logic [HDR_W-1:0]   header;     // header byte
   } pipk_op_type;

   // bit length of the largest index, rounded to a supported size
   function automatic logic [BITS_W-1:0] pipk_bits(input logic [INDEX_W-1:0] max_index);
      logic [BITS_W-1:0] n;
      n = '0;
      for (int i = 0; i < INDEX_W; i++) begin
         if (max_index[i]) begin
            n = BITS_W'(i + 1);
         end
      end
      if (n == '0) begin
         n = BITS_W'(1);
      end
      if (n == BITS_W'(7)) begin
         n = BITS_W'(8);
      end else if (n >= BITS_W'(9)) begin
         n = BITS_W'(16);
      end
      return n;
   endfunction

   // values per 32-bit word
   function automatic logic [SLOT_W:0] pipk_per_word(input logic [BITS_W-1:0] bits);
      logic [SLOT_W:0] p;
      case (bits)
         BITS_W'(1): p = (SLOT_W+1)'(32);
         BITS_W'(2): p = (SLOT_W+1)'(16);
         BITS_W'(3): p = (SLOT_W+1)'(10);
         BITS_W'(4): p = (SLOT_W+1)'(8);
         BITS_W'(5): p = (SLOT_W+1)'(6);
         BITS_W'(6): p = (SLOT_W+1)'(5);
         BITS_W'(8): p = (SLOT_W+1)'(4);
         default:    p = (SLOT_W+1)'(2);
      endcase
      return p;
   endfunction

   function automatic logic [INDEX_W-1:0] pipk_mask(input logic [BITS_W-1:0] bits);
      logic [INDEX_W:0] m;
      m = ((INDEX_W+1)'(1) << bits) - (INDEX_W+1)'(1);
      return m[INDEX_W-1:0];
   endfunction

endpackage

### hw/rtl/pipk_front.sv
// pipk_front: takes index values, tracks array position and word slot, classifies each value
// depends on pipk_pkg

module pipk_front
   import pipk_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [INDEX_W-1:0]   index_value,
   input  logic [INDEX_W-1:0]   max_index,
   output pipk_op_type          op
);

   logic [POS_W-1:0]  position_ff, position_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [BITS_W-1:0] bits;
   logic [SLOT_W:0]   per_word;
   logic [SPAN_W-1:0] span;
   logic [SLOT_W-1:0] slot_inc;
   logic              last;
   logic              word_full;

   always_comb begin
      bits      = pipk_bits(max_index);
      per_word  = pipk_per_word(bits);
      span      = SPAN_W'(slot_ff) * SPAN_W'(bits);
      slot_inc  = slot_ff + SLOT_W'(1);
      last      = (position_ff == POS_W'(ARRAY_LENGTH - 1));
      // slot wrapping to zero also ends the word
      word_full = ({1'b0, slot_inc} >= per_word) || (slot_inc == '0);

      op.value  = index_value & pipk_mask(bits);
      op.shift  = span[SLOT_W-1:0];
      op.fits   = (span < SPAN_W'(WORD_W));
      op.first  = (position_ff == '0);
      op.close  = last || word_full;
      op.last   = last;
      op.header = HDR_W'({bits, 1'b0});

      position_in = last ? '0 : position_ff + POS_W'(1);
      slot_in     = (last || word_full) ? '0 : slot_inc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         slot_ff     <= '0;
      end else if (accept) begin
         position_ff <= position_in;
         slot_ff     <= slot_in;
      end
   end

   a_start_of_array_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (position_ff == '0) |-> (slot_ff == '0))
      else $error("slot not zero at start of array");

endmodule

### hw/rtl/pipk_queue.sv
// pipk_queue: short queue of packing steps between front and back
// depends on pipk_pkg

module pipk_queue
   import pipk_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         wr_en,
   input  pipk_op_type  wr_op,
   output logic         full,
   input  logic         rd_en,
   output pipk_op_type  rd_op,
   output logic         empty
);

   pipk_op_type             mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;
   logic                    do_wr, do_rd;

   assign full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign do_wr = wr_en && !full;
   assign do_rd = rd_en && !empty;
   assign rd_op = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (do_rd) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_pointers_track_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with empty count");

endmodule

### hw/rtl/pipk_back.sv
// pipk_back: merges values into the word accumulator and holds the result register
// depends on pipk_pkg

module pipk_back
   import pipk_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  pipk_op_type        op,
   input  logic               op_valid,
   output logic               op_take,
   output logic               rsp_valid,
   input  logic               rsp_take,
   output logic [WORD_W-1:0]  rsp_packed_word,
   output logic               rsp_is_header,
   output logic               rsp_is_last
);

   logic [WORD_W-1:0] acc_ff, acc_in, merged;
   logic              valid_ff, valid_in;
   logic [WORD_W-1:0] word_ff;
   logic              header_ff, last_ff;
   logic              load_ok;
   logic              emit;

   always_comb begin
      load_ok = !valid_ff || rsp_take;
      op_take = op_valid && load_ok;
      merged  = op.fits ? (acc_ff | (WORD_W'(op.value) << op.shift)) : acc_ff;
      acc_in  = op.close ? '0 : merged;
      emit    = op.first || op.close;
      valid_in = valid_ff;
      if (op_take) begin
         valid_in = emit;
      end else if (rsp_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (op_take) begin
            acc_ff <= acc_in;
         end
         valid_ff <= valid_in;
      end
   end

   // header wins over a word closing in the same beat
   always_ff @(posedge clock) begin
      if (op_take) begin
         word_ff   <= op.first ? WORD_W'(op.header) : merged;
         header_ff <= op.first;
         last_ff   <= !op.first && op.last;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_packed_word = word_ff;
   assign rsp_is_header   = header_ff;
   assign rsp_is_last     = last_ff;

   a_header_not_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> !(header_ff && last_ff))
      else $error("header flagged as last");

   a_header_upper_zero: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && header_ff) |-> (word_ff[WORD_W-1:HDR_W] == '0))
      else $error("header word has upper bits set");

endmodule

### hw/rtl/paletted_index_word_packer.sv
// paletted_index_word_packer: top level of the packer, config register and queue wiring
// depends on pipk_pkg, pipk_front, pipk_queue, pipk_back

// Takes one 16-bit palette index per clock while full is low and packs an array of ARRAY_LENGTH
// (4096) indexes into 32-bit words from the low bits upward. The bits per value follow
// csr_max_index (1..6, 8 or 16); the first index of each array also yields a header result holding
// bits per value shifted left by one. Full words come out as they fill; the word with the last index
// comes out flagged last. Sustained rate is one index per cycle while results are popped: the front
// updates position and slot for each index taken and the back merges one value per cycle into the
// accumulator. A result passes a four-entry queue and then the result register to the rsp ports;
// queue and register let input and output stall on their own. Write csr_max_index only while idle.

module paletted_index_word_packer
   import pipk_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic [INDEX_W-1:0]  req_index_value,
   output logic                empty,
   input  logic                pop,
   output logic [WORD_W-1:0]   rsp_packed_word,
   output logic                rsp_is_header,
   output logic                rsp_is_last,
   input  logic                csr_write_en,
   input  logic [INDEX_W-1:0]  csr_max_index
);

   logic [INDEX_W-1:0] max_index_ff;
   logic               accept;
   pipk_op_type        front_op, back_op;
   logic               q_empty, q_take;
   logic               rsp_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_index_ff <= '0;
      end else if (csr_write_en) begin
         max_index_ff <= csr_max_index;
      end
   end

   assign accept = push && !full;

   pipk_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .index_value (req_index_value),
      .max_index   (max_index_ff),
      .op          (front_op)
   );

   pipk_queue u_queue (
      .clock (clock),
      .reset (reset),
      .wr_en (accept),
      .wr_op (front_op),
      .full  (full),
      .rd_en (q_take),
      .rd_op (back_op),
      .empty (q_empty)
   );

   pipk_back u_back (
      .clock           (clock),
      .reset           (reset),
      .op              (back_op),
      .op_valid        (!q_empty),
      .op_take         (q_take),
      .rsp_valid       (rsp_valid),
      .rsp_take        (pop),
      .rsp_packed_word (rsp_packed_word),
      .rsp_is_header   (rsp_is_header),
      .rsp_is_last     (rsp_is_last)
   );

   assign empty = !rsp_valid;

endmodule
